// ----- rtl/ils_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the indexed list store.
// No dependencies.
package ils_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 9;
  localparam int CNT_W    = 9;
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         length;
  } ils_res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ils_mem_req_t;

endpackage

// ----- rtl/ils_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ils_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the list store: decodes a transaction and walks a shared
// cursor up or down through the element RAM. Depends on ils_pkg.
module ils_ctrl
  import ils_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     busy_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output ils_res_t                 res_o,
  output ils_mem_req_t             mem_o,
  input  logic [DATA_W-1:0]        mem_rdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_UP     = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_DN     = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic              wr_pend_q, wr_pend_d;
  logic [IDX_W-1:0]  wr_addr_q, wr_addr_d;
  logic [ACT_W-1:0]  act_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] dout_q, dout_d;
  logic [STAT_W-1:0] stat_q, stat_d;

  // shared cursor step and compare
  logic              step_up;
  logic [CNT_W-1:0]  cursor_nx;
  logic              more;

  assign step_up   = (state_q == S_UP);
  assign cursor_nx = step_up ? (cursor_q - CNT_W'(1)) : (cursor_q + CNT_W'(1));
  assign more      = step_up ? (cursor_q > pos_q) : (cursor_nx < count_q);

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FINISH);
  assign res_o       = '{data: dout_q, status: stat_q, length: count_q};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    wr_pend_d = wr_pend_q;
    wr_addr_d = wr_addr_q;
    dout_d    = dout_q;
    stat_d    = stat_q;
    mem_o     = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_START;
        end
      end
      S_START: begin
        dout_d    = '0;
        stat_d    = ST_OK;
        wr_pend_d = 1'b0;
        state_d   = S_FINISH;
        unique case (act_q)
          ACT_APPEND: begin
            if (count_q == CAP_CNT) begin
              stat_d = ST_FULL;
            end else begin
              mem_o.we    = 1'b1;
              mem_o.waddr = count_q[IDX_W-1:0];
              mem_o.wdata = val_q;
              count_d     = count_q + CNT_W'(1);
            end
          end
          ACT_INSERT: begin
            if (pos_q > count_q) begin
              stat_d = ST_RANGE;
            end else if (count_q == CAP_CNT) begin
              stat_d = ST_FULL;
            end else begin
              cursor_d = count_q;
              state_d  = S_UP;
            end
          end
          ACT_READ: begin
            if (pos_q >= count_q) begin
              stat_d = ST_RANGE;
            end else begin
              mem_o.raddr = pos_q[IDX_W-1:0];
              state_d     = S_RDWAIT;
            end
          end
          ACT_WRITE: begin
            if (pos_q >= count_q) begin
              stat_d = ST_RANGE;
            end else begin
              mem_o.we    = 1'b1;
              mem_o.waddr = pos_q[IDX_W-1:0];
              mem_o.wdata = val_q;
            end
          end
          ACT_REMOVE: begin
            if (pos_q >= count_q) begin
              stat_d = ST_RANGE;
            end else begin
              cursor_d = pos_q;
              state_d  = S_DN;
            end
          end
          ACT_POP: begin
            if (count_q == '0) begin
              stat_d = ST_EMPTY;
            end else begin
              count_d     = count_q - CNT_W'(1);
              mem_o.raddr = count_d[IDX_W-1:0];
              state_d     = S_RDWAIT;
            end
          end
          ACT_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_RDWAIT: begin
        dout_d  = mem_rdata_i;
        state_d = S_FINISH;
      end
      S_UP, S_DN: begin
        mem_o.we    = wr_pend_q;
        mem_o.waddr = wr_addr_q;
        mem_o.wdata = mem_rdata_i;
        if (more) begin
          mem_o.raddr = step_up ? cursor_nx[IDX_W-1:0] : cursor_nx[IDX_W-1:0];
          wr_pend_d   = 1'b1;
          wr_addr_d   = cursor_q[IDX_W-1:0];
          cursor_d    = cursor_nx;
        end else begin
          wr_pend_d = 1'b0;
          if (step_up) begin
            state_d = S_PLACE;
          end else begin
            count_d = count_q - CNT_W'(1);
            state_d = S_FINISH;
          end
        end
      end
      S_PLACE: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q[IDX_W-1:0];
        mem_o.wdata = val_q;
        count_d     = count_q + CNT_W'(1);
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      act_q <= action_i;
      pos_q <= position_i;
      val_q <= data_in_i;
    end
    cursor_q  <= cursor_d;
    wr_addr_q <= wr_addr_d;
    dout_q    <= dout_d;
    stat_q    <= stat_d;
  end

endmodule

// ----- rtl/indexed_list_store.sv -----
`timescale 1ns / 1ps
// Indexed list store top level: sequencer, element RAM and output register.
// Depends on ils_pkg, ils_ctrl, ils_ram.
// Append, write, clear, unused codes and errors go straight to the result;
// read and pop wait for the registered RAM read; insert and remove walk the
// elements between the position and the end of the list.
// One transaction at a time: the next is taken from the cycle after the result
// leaves the sequencer; the longest transactions are the walks, one element per
// cycle through the single write port of the RAM.
// Reset empties the list at once; RAM contents are not cleared.
module indexed_list_store
  import ils_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [CNT_W-1:0]         length_o
);

  logic              busy;
  logic              res_valid;
  logic              res_ready;
  ils_res_t          res;
  ils_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              out_valid_q;
  ils_res_t          out_q;

  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .busy_o      (busy),
    .action_i    (action_i),
    .position_i  (position_i),
    .data_in_i   (data_in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  ils_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_q.data;
  assign status_o    = out_q.status;
  assign length_o    = out_q.length;

endmodule

// ----- rtl/ils_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for indexed_list_store, bound to the top level.
// Depends on ils_pkg.
module ils_checker
  import ils_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] data_out_o,
  input logic [STAT_W-1:0]        status_o,
  input logic [CNT_W-1:0]         length_o
);

  // one transaction in flight: stall rises right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a second transaction while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(data_out_o)
      && $stable(status_o) && $stable(length_o)))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (data_out_o == '0))
    else $error("error result carries data");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (length_o == '0))
    else $error("empty status with non-zero length");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (length_o == CAP_CNT))
    else $error("full status below capacity");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);
